FILE: sv/dtda_pkg.sv
// ----------------------------------------------------------------------------
// dtda_pkg
// Shared types and constants for the double to decimal text converter.
// ----------------------------------------------------------------------------
package dtda_pkg;

	localparam int MAX_FRACTION_DIGITS_DEF = 6;
	localparam int FRACTION_BITS_DEF       = 64;

	// integer part never exceeds 2^63-1: 63 bits, 19 decimal digits
	localparam int IPART_W    = 63;
	localparam int NUM_DIGITS = 19;
	localparam int CNT_W      = $clog2(IPART_W);
	localparam int NDIG_W     = $clog2(NUM_DIGITS + 1);

	localparam logic [10:0] EXP_SAT  = 11'd1086;
	localparam logic [10:0] EXP_INT  = 11'd1075;
	localparam logic [10:0] EXP_MAX  = 11'd2047;
	localparam logic [10:0] EXP_SUBN = 11'd1074;

	localparam logic [6:0] CH_0    = 7'h30;
	localparam logic [6:0] CH_9    = 7'h39;
	localparam logic [6:0] CH_DOT  = 7'h2E;
	localparam logic [6:0] CH_DASH = 7'h2D;

	typedef struct packed {
		logic clr;
		logic dabble;
		logic emit;
	} cell_ctrl_t;

endpackage

FILE: sv/double_to_decimal_ascii_unit.sv
// ----------------------------------------------------------------------------
// double_to_decimal_ascii_unit
// Converts the raw bits of a double into its decimal ASCII text, one
// character per output item, with tlast on the final character.
// ----------------------------------------------------------------------------
// channel  dir  tdata                      tlast      tuser
// s_*      in   [63:0] value_bits          -          -
// m_*      out  [6:0] char_code, [7] zero  last_char  saturated
//
// an accepted item is shifted from binary to BCD through the 19-cell digit
// chain, its leading zeros are dropped, then its characters (at most 27) are
// sent in order while the output is not stalled.
// a new item is taken once the last character is in the output register.
// arst_n clears the sequencer and the output valid; digit cells keep no reset.
// ----------------------------------------------------------------------------
module double_to_decimal_ascii_unit
	import dtda_pkg::*;
#(
	parameter int MAX_FRACTION_DIGITS = MAX_FRACTION_DIGITS_DEF,
	parameter int FRACTION_BITS       = FRACTION_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [63:0] value_bits
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [6:0] char_code, [7] zero
	output logic        m_tlast,
	output logic        m_tuser    // [0] saturated
);

	localparam int FB    = FRACTION_BITS;
	localparam int FCW   = $clog2(MAX_FRACTION_DIGITS + 2);
	localparam int XW    = 53 + FB;
	localparam logic [63:0] FRAC_THR64 =
		({64{1'b1}} >> (64 - FRACTION_BITS)) / 64'd10000000000;
	localparam logic [FB-1:0] FRAC_THR = FRAC_THR64[FB-1:0];

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CONV = 3'd1;
	localparam logic [2:0] ST_SKIP = 3'd2;
	localparam logic [2:0] ST_SIGN = 3'd3;
	localparam logic [2:0] ST_INT  = 3'd4;
	localparam logic [2:0] ST_DOT  = 3'd5;
	localparam logic [2:0] ST_FRAC = 3'd6;

	logic [2:0]        state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [NDIG_W-1:0] ndig_q;
	logic [FCW-1:0]    fcnt_q;
	logic [IPART_W-1:0] ip_q;
	logic [FB-1:0]     frac_q;
	logic              neg_q;
	logic              sat_q;
	logic              m_tvalid_q;
	logic [7:0]        m_tdata_q;
	logic              m_tlast_q;
	logic              m_tuser_q;

	// input decode
	logic [10:0]        expo;
	logic [51:0]        mant;
	logic [52:0]        m53;
	logic               is_zero, is_sat, is_nan;
	logic [10:0]        rsh;
	logic [XW-1:0]      xsh;
	logic [IPART_W-1:0] ip_d;
	logic [FB-1:0]      frac_d;
	logic               neg_d;

	always_comb begin
		expo    = s_tdata[62:52];
		mant    = s_tdata[51:0];
		is_zero = (expo == 11'd0) && (mant == 52'd0);
		is_sat  = (expo >= EXP_SAT);
		is_nan  = (expo == EXP_MAX) && (mant != 52'd0);
		m53     = {(expo != 11'd0), mant};
		rsh     = (expo == 11'd0) ? EXP_SUBN : EXP_INT - expo;
		xsh     = {m53, {FB{1'b0}}} >> rsh;
		neg_d   = s_tdata[63] && !is_nan && !is_zero;
		if (is_sat) begin
			ip_d   = {IPART_W{1'b1}};
			frac_d = '0;
		end else if (expo >= EXP_INT) begin
			ip_d   = {{(IPART_W-53){1'b0}}, m53} << (expo - EXP_INT);
			frac_d = '0;
		end else begin
			ip_d   = {{(IPART_W-53){1'b0}}, xsh[XW-1:FB]};
			frac_d = xsh[FB-1:0];
		end
	end

	// digit chain
	cell_ctrl_t ctrl;
	logic [NUM_DIGITS-1:0] cin_w, cout_w;
	logic [3:0]            digit_w [NUM_DIGITS];
	logic [3:0]            dlow_w  [NUM_DIGITS];

	assign cin_w[0]  = ip_q[IPART_W-1];
	assign dlow_w[0] = 4'd0;

	for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
		if (i > 0) begin : g_link
			assign cin_w[i]  = cout_w[i-1];
			assign dlow_w[i] = digit_w[i-1];
		end
		dtda_cell u_cell (
			.clk   (clk),
			.ctrl  (ctrl),
			.cin   (cin_w[i]),
			.dlow  (dlow_w[i]),
			.cout  (cout_w[i]),
			.digit (digit_w[i])
		);
	end

	// fraction times ten
	logic [FB+3:0] prod;
	logic [3:0]    top;
	logic          frac_big, new_big, load_ok, acc, ld, lst;
	logic [6:0]    ch;

	always_comb begin
		prod     = ({4'd0, frac_q} << 3) + ({4'd0, frac_q} << 1);
		top      = digit_w[NUM_DIGITS-1];
		frac_big = frac_q > FRAC_THR;
		new_big  = prod[FB-1:0] > FRAC_THR;
		load_ok  = !m_tvalid_q || m_tready;
		acc      = s_tvalid && s_tready;
		ctrl     = '0;
		ld       = 1'b0;
		lst      = 1'b0;
		ch       = CH_0;
		case (state_q)
			ST_IDLE: begin
				ctrl.clr = acc;
			end
			ST_CONV: begin
				ctrl.dabble = 1'b1;
			end
			ST_SKIP: begin
				ctrl.emit = (top == 4'd0) && (ndig_q > NDIG_W'(1));
			end
			ST_SIGN: begin
				ld = load_ok;
				ch = CH_DASH;
			end
			ST_INT: begin
				ld        = load_ok;
				ctrl.emit = load_ok;
				ch        = CH_0 + {3'd0, top};
				lst       = (ndig_q == NDIG_W'(1)) && !frac_big;
			end
			ST_DOT: begin
				ld  = load_ok;
				ch  = CH_DOT;
				lst = (MAX_FRACTION_DIGITS == 0);
			end
			ST_FRAC: begin
				ld  = load_ok;
				ch  = CH_0 + {3'd0, prod[FB+3:FB]};
				lst = !new_big || (fcnt_q == FCW'(MAX_FRACTION_DIGITS - 1));
			end
			default: begin
				ld = 1'b0;
			end
		endcase
	end

	assign s_tready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			ndig_q     <= '0;
			fcnt_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (ld) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						cnt_q   <= '0;
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(IPART_W - 1)) begin
						ndig_q  <= NDIG_W'(NUM_DIGITS);
						state_q <= ST_SKIP;
					end
				end
				ST_SKIP: begin
					if (ctrl.emit) begin
						ndig_q <= ndig_q - NDIG_W'(1);
					end else begin
						state_q <= neg_q ? ST_SIGN : ST_INT;
					end
				end
				ST_SIGN: begin
					if (ld) begin
						state_q <= ST_INT;
					end
				end
				ST_INT: begin
					if (ld) begin
						ndig_q <= ndig_q - NDIG_W'(1);
						if (ndig_q == NDIG_W'(1)) begin
							state_q <= frac_big ? ST_DOT : ST_IDLE;
						end
					end
				end
				ST_DOT: begin
					if (ld) begin
						fcnt_q  <= '0;
						state_q <= (MAX_FRACTION_DIGITS == 0) ? ST_IDLE : ST_FRAC;
					end
				end
				ST_FRAC: begin
					if (ld) begin
						fcnt_q <= fcnt_q + FCW'(1);
						if (lst) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			ip_q   <= ip_d;
			frac_q <= frac_d;
			neg_q  <= neg_d;
			sat_q  <= is_sat;
		end else if (state_q == ST_CONV) begin
			ip_q <= ip_q << 1;
		end else if (state_q == ST_FRAC && ld) begin
			frac_q <= prod[FB-1:0];
		end
		if (ld) begin
			m_tdata_q <= {1'b0, ch};
			m_tlast_q <= lst;
			m_tuser_q <= sat_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;
	assign m_tuser  = m_tuser_q;

	a_accept_starts_conv: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q == ST_CONV)
		else $error("accepted item did not start conversion");

	a_int_has_digit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_INT |-> ndig_q != '0)
		else $error("integer digit count ran out");

	a_frac_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FRAC |-> fcnt_q < FCW'(MAX_FRACTION_DIGITS))
		else $error("too many fraction digits");

	a_char_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[6:0] >= CH_0 && m_tdata[6:0] <= CH_9)
			|| m_tdata[6:0] == CH_DOT || m_tdata[6:0] == CH_DASH)
		else $error("illegal output character");

endmodule

FILE: sv/dtda_cell.sv
// ----------------------------------------------------------------------------
// dtda_cell
// One BCD digit of the conversion chain: add-3 and shift while converting,
// plain shift toward the top while dropping leading zeros and sending digits.
// ----------------------------------------------------------------------------
module dtda_cell
	import dtda_pkg::*;
(
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  logic       cin,
	input  logic [3:0] dlow,
	output logic       cout,
	output logic [3:0] digit
);

	logic [3:0] digit_q;
	logic [3:0] adj;

	always_comb begin
		adj = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
	end

	assign cout  = adj[3];
	assign digit = digit_q;

	always_ff @(posedge clk) begin
		if (ctrl.clr) begin
			digit_q <= 4'd0;
		end else if (ctrl.dabble) begin
			digit_q <= {adj[2:0], cin};
		end else if (ctrl.emit) begin
			digit_q <= dlow;
		end
	end

endmodule
